// ===== hdl/segment_triangle_intersect_macros.svh =====
// Assertion macros shared by the segment / triangle intersect RTL.
`ifndef SEGMENT_TRIANGLE_INTERSECT_MACROS_SVH
`define SEGMENT_TRIANGLE_INTERSECT_MACROS_SVH
`ifndef ASSERT_OFF
// property holds at every clock edge out of reset
`define STINT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// antecedent implies consequent in the following cycle
`define STINT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define STINT_ASSERT(lbl, clk, rst, prop, msg)
`define STINT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/stint_pkg.sv =====
package stint_pkg;

   localparam int FIELD_BITS       = 48;
   localparam int OUT_BITS         = 32;
   localparam int DEF_COORD_BITS   = 16;
   localparam int DEF_FRAC_BITS    = 16;
   // geometry pipe: differences, products, cross terms, dot products, sums
   localparam int GEOM_LAT         = 5;
   // divider: magnitude, range check, one stage per quotient bit, saturation
   localparam int DIV_LAT          = OUT_BITS + 3;

   typedef struct packed {
      logic [FIELD_BITS-1:0] vertex_2;
      logic [FIELD_BITS-1:0] vertex_1;
      logic [FIELD_BITS-1:0] vertex_0;
      logic [FIELD_BITS-1:0] seg_end;
      logic [FIELD_BITS-1:0] seg_start;
   } stint_req_type;

   typedef struct packed {
      logic                       is_parallel;
      logic signed [OUT_BITS-1:0] bary_v;
      logic signed [OUT_BITS-1:0] bary_u;
      logic signed [OUT_BITS-1:0] seg_param;
   } stint_rsp_type;

endpackage

// ===== hdl/stint_geom.sv =====
module stint_geom #(
   parameter int COORD_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  stint_pkg::stint_req_type req,
   output logic                  out_valid,
   output logic signed [3*COORD_BITS+5:0] det,
   output logic signed [3*COORD_BITS+5:0] num_t,
   output logic signed [3*COORD_BITS+5:0] num_u,
   output logic signed [3*COORD_BITS+5:0] num_v
);
   import stint_pkg::*;

   localparam int CW = COORD_BITS + 1;
   localparam int PW = 2 * CW;
   localparam int XW = PW + 1;
   localparam int QW = CW + XW;
   localparam int TW = QW + 2;
   localparam int NXT1 [3] = '{1, 2, 0};
   localparam int NXT2 [3] = '{2, 0, 1};

   logic               v_ff [1:4];
   logic               v5_ff;
   logic signed [CW-1:0] c0_in [3], c1_in [3], c2_in [3], r_in [3];
   logic signed [CW-1:0] c0_ff [3], c1_ff [3], c2_ff [3], r_ff [3];
   logic signed [CW-1:0] c0_2_ff [3], r_2_ff [3], c0_3_ff [3], r_3_ff [3];
   // products of the three cross terms: c1 x c2, r x c2, c1 x r
   logic signed [PW-1:0] pl_ff [3][3], pr_ff [3][3];
   logic signed [XW-1:0] x_ff [3][3];
   // dot products: det, t, u, v
   logic signed [QW-1:0] d_ff [4][3];
   logic signed [TW-1:0] s_ff [4];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [COORD_BITS-1:0] a, b, p0, p1, p2;
         a  = req.seg_start[k*COORD_BITS +: COORD_BITS];
         b  = req.seg_end[k*COORD_BITS +: COORD_BITS];
         p0 = req.vertex_0[k*COORD_BITS +: COORD_BITS];
         p1 = req.vertex_1[k*COORD_BITS +: COORD_BITS];
         p2 = req.vertex_2[k*COORD_BITS +: COORD_BITS];
         c0_in[k] = CW'(a) - CW'(b);
         c1_in[k] = CW'(p1) - CW'(p0);
         c2_in[k] = CW'(p2) - CW'(p0);
         r_in[k]  = CW'(a) - CW'(p0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= 4; i++) v_ff[i] <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v_ff[1] <= in_valid;
         for (int i = 2; i <= 4; i++) v_ff[i] <= v_ff[i-1];
         v5_ff <= v_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            c0_ff[k] <= c0_in[k];
            c1_ff[k] <= c1_in[k];
            c2_ff[k] <= c2_in[k];
            r_ff[k]  <= r_in[k];
            c0_2_ff[k] <= c0_ff[k];
            r_2_ff[k]  <= r_ff[k];
            c0_3_ff[k] <= c0_2_ff[k];
            r_3_ff[k]  <= r_2_ff[k];
            pl_ff[0][k] <= PW'(c1_ff[NXT1[k]]) * PW'(c2_ff[NXT2[k]]);
            pr_ff[0][k] <= PW'(c1_ff[NXT2[k]]) * PW'(c2_ff[NXT1[k]]);
            pl_ff[1][k] <= PW'(r_ff[NXT1[k]]) * PW'(c2_ff[NXT2[k]]);
            pr_ff[1][k] <= PW'(r_ff[NXT2[k]]) * PW'(c2_ff[NXT1[k]]);
            pl_ff[2][k] <= PW'(c1_ff[NXT1[k]]) * PW'(r_ff[NXT2[k]]);
            pr_ff[2][k] <= PW'(c1_ff[NXT2[k]]) * PW'(r_ff[NXT1[k]]);
            for (int j = 0; j < 3; j++) x_ff[j][k] <= XW'(pl_ff[j][k]) - XW'(pr_ff[j][k]);
            d_ff[0][k] <= QW'(c0_3_ff[k]) * QW'(x_ff[0][k]);
            d_ff[1][k] <= QW'(r_3_ff[k]) * QW'(x_ff[0][k]);
            d_ff[2][k] <= QW'(c0_3_ff[k]) * QW'(x_ff[1][k]);
            d_ff[3][k] <= QW'(c0_3_ff[k]) * QW'(x_ff[2][k]);
         end
         for (int j = 0; j < 4; j++)
            s_ff[j] <= TW'(d_ff[j][0]) + TW'(d_ff[j][1]) + TW'(d_ff[j][2]);
      end
   end

   assign out_valid = v5_ff;
   assign det   = s_ff[0];
   assign num_t = s_ff[1];
   assign num_u = s_ff[2];
   assign num_v = s_ff[3];

endmodule

// ===== hdl/stint_div.sv =====
module stint_div #(
   parameter int TW        = 54,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 adv,
   input  logic signed [TW-1:0] num,
   input  logic signed [TW-1:0] den,
   output logic [stint_pkg::OUT_BITS-1:0] quo
);
   import stint_pkg::*;

   localparam int XW = TW + FRAC_BITS;
   localparam int RW = XW + OUT_BITS;
   localparam logic [OUT_BITS-1:0] MAX_POS = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic [OUT_BITS-1:0] MAX_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};

   logic [TW-1:0]  nm_in, dm_in, nm_ff, dm_ff;
   logic           neg_ff;
   logic [XW-1:0]  rem_ff [0:OUT_BITS-1];
   logic [TW-1:0]  dm_st_ff [0:OUT_BITS-1];
   logic [OUT_BITS-1:0] q_ff [0:OUT_BITS];
   logic           neg_st_ff [0:OUT_BITS];
   logic           ovf_st_ff [0:OUT_BITS];
   logic [OUT_BITS-1:0] quo_in, quo_ff;

   assign nm_in = num[TW-1] ? (~num + 1'b1) : num;
   assign dm_in = den[TW-1] ? (~den + 1'b1) : den;

   always_ff @(posedge clock) begin
      if (adv) begin
         nm_ff  <= nm_in;
         dm_ff  <= dm_in;
         neg_ff <= num[TW-1] ^ den[TW-1];
         // quotient needs more than OUT_BITS bits: saturate at the end
         rem_ff[0]    <= {nm_ff, {FRAC_BITS{1'b0}}};
         dm_st_ff[0]  <= dm_ff;
         q_ff[0]      <= '0;
         neg_st_ff[0] <= neg_ff;
         ovf_st_ff[0] <= RW'({nm_ff, {FRAC_BITS{1'b0}}}) >= (RW'(dm_ff) << OUT_BITS);
      end
   end

   for (genvar s = 0; s < OUT_BITS; s++) begin : g_step
      localparam int SH = OUT_BITS - 1 - s;
      logic [RW-1:0] trial;
      logic          take;
      assign trial = RW'(dm_st_ff[s]) << SH;
      assign take  = RW'(rem_ff[s]) >= trial;
      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff[s+1]      <= {q_ff[s][OUT_BITS-2:0], take};
            neg_st_ff[s+1] <= neg_st_ff[s];
            ovf_st_ff[s+1] <= ovf_st_ff[s];
         end
      end
      if (s < OUT_BITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[s+1]   <= take ? XW'(RW'(rem_ff[s]) - trial) : rem_ff[s];
               dm_st_ff[s+1] <= dm_st_ff[s];
            end
         end
      end
   end

   always_comb begin
      logic [OUT_BITS-1:0] q;
      q = q_ff[OUT_BITS];
      if (neg_st_ff[OUT_BITS]) begin
         if (ovf_st_ff[OUT_BITS] || (q[OUT_BITS-1] && |q[OUT_BITS-2:0])) quo_in = MAX_NEG;
         else quo_in = ~q + 1'b1;
      end else begin
         if (ovf_st_ff[OUT_BITS] || q[OUT_BITS-1]) quo_in = MAX_POS;
         else quo_in = q;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) quo_ff <= quo_in;
   end

   assign quo = quo_ff;

endmodule

// ===== hdl/segment_triangle_intersect.sv =====
// Channel  Ports                         Payload          Direction
// req      req_valid/req_ready/req_data  stint_req_type   in
// rsp      rsp_valid/rsp_ready/rsp_data  stint_rsp_type   out
//
// One beat in per cycle while the result side does not stall; each beat runs through
// the geometry pipe, the dividers and an output register, in that order.
// Most of the pipe depth is in the restoring dividers: one stage per quotient bit.
// All stages move together; rsp_ready low with a result held freezes the pipe.
// Reset (synchronous, high) clears the valid bits only; data stages are free.
`include "segment_triangle_intersect_macros.svh"
module segment_triangle_intersect #(
   parameter int COORD_BITS = stint_pkg::DEF_COORD_BITS,
   parameter int FRAC_BITS  = stint_pkg::DEF_FRAC_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  stint_pkg::stint_req_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output stint_pkg::stint_rsp_type rsp_data
);
   import stint_pkg::*;

   localparam int TW = 3 * COORD_BITS + 6;

   logic                 adv;
   logic                 g_valid;
   logic signed [TW-1:0] det, num_t, num_u, num_v;
   logic [OUT_BITS-1:0]  q_t, q_u, q_v;
   // valid and parallel flags ride beside the dividers
   logic                 vl_ff [DIV_LAT];
   logic                 par_ff [DIV_LAT];
   logic                 rsp_valid_ff;
   stint_rsp_type        rsp_data_in, rsp_data_ff;

   // whole pipe advances unless a finished beat is waiting
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   stint_geom #(.COORD_BITS(COORD_BITS)) u_geom (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .req       (req_data),
      .out_valid (g_valid),
      .det       (det),
      .num_t     (num_t),
      .num_u     (num_u),
      .num_v     (num_v)
   );

   stint_div #(.TW(TW), .FRAC_BITS(FRAC_BITS)) u_div_t (
      .clock (clock), .adv (adv), .num (num_t), .den (det), .quo (q_t)
   );
   stint_div #(.TW(TW), .FRAC_BITS(FRAC_BITS)) u_div_u (
      .clock (clock), .adv (adv), .num (num_u), .den (det), .quo (q_u)
   );
   stint_div #(.TW(TW), .FRAC_BITS(FRAC_BITS)) u_div_v (
      .clock (clock), .adv (adv), .num (num_v), .den (det), .quo (q_v)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) vl_ff[i] <= 1'b0;
      end else if (adv) begin
         vl_ff[0] <= g_valid;
         for (int i = 1; i < DIV_LAT; i++) vl_ff[i] <= vl_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         par_ff[0] <= (det == '0);
         for (int i = 1; i < DIV_LAT; i++) par_ff[i] <= par_ff[i-1];
      end
   end

   // zero determinant: flag set, all three quotients forced to zero
   always_comb begin
      rsp_data_in.is_parallel = par_ff[DIV_LAT-1];
      rsp_data_in.seg_param   = par_ff[DIV_LAT-1] ? '0 : q_t;
      rsp_data_in.bary_u      = par_ff[DIV_LAT-1] ? '0 : q_u;
      rsp_data_in.bary_v      = par_ff[DIV_LAT-1] ? '0 : q_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vl_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `STINT_ASSERT(a_par_zero, clock, reset, !(rsp_valid_ff && rsp_data_ff.is_parallel) || (rsp_data_ff.seg_param == '0 && rsp_data_ff.bary_u == '0 && rsp_data_ff.bary_v == '0), "parallel result with nonzero fields")
   `STINT_ASSERT_NEXT(a_tail, clock, reset, vl_ff[DIV_LAT-1] && adv, rsp_valid_ff, "tail beat lost on way to output")
   `STINT_ASSERT_NEXT(a_freeze, clock, reset, !adv, vl_ff[0] == $past(vl_ff[0]) && vl_ff[DIV_LAT-1] == $past(vl_ff[DIV_LAT-1]), "pipe moved during stall")
   `STINT_ASSERT_NEXT(a_par_flag, clock, reset, g_valid && adv && det == '0, vl_ff[0] && par_ff[0], "zero determinant not flagged")

endmodule
